// ===== src/depth_crop_downscale_macros.svh =====
// Assertion helpers for the top-level module, the only file that carries checks.
// Both use the enclosing module's clock and reset.
`ifndef DEPTH_CROP_DOWNSCALE_MACROS_SVH
`define DEPTH_CROP_DOWNSCALE_MACROS_SVH

// same-cycle implication
`define DCD_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("depth_crop_downscale: same-cycle check failed");

// next-cycle implication
`define DCD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("depth_crop_downscale: next-cycle check failed");

`endif

// ===== src/dcd_pkg.sv =====
`timescale 1ns / 1ps
package dcd_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = 13;
   localparam int CNT_W     = 12;
   localparam int ACC_W     = 32;
   localparam int FRAC_BITS = 16;
   localparam int SCALE_W   = 29;
   localparam int MM_W      = 16;
   localparam int DEPTH_W   = 23;
   localparam int CSR_W     = 29;
   localparam int CSR_IDX_W = 3;
   localparam int PICK_W    = ACC_W - FRAC_BITS + 1;

   localparam logic [DIM_W-1:0]   MAX_DIM_V = DIM_W'(MAX_DIM);
   localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << FRAC_BITS;

   // mm -> m Q7.16: q = floor((mm*8192 + 62) / 125), division done as
   // multiply by ceil(2^36/125) and a shift (exact for numerators < 2^29)
   localparam int NUM_PAD   = 13;
   localparam int NUM_W     = MM_W + NUM_PAD;
   localparam logic [NUM_PAD-1:0] NUM_BIAS = NUM_PAD'(62);
   localparam int RECIP_W   = 30;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(549755814);
   localparam int PROD_W    = NUM_W + RECIP_W;
   localparam int DIV_SHIFT = 36;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Q16     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CROP_COL      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CROP_ROW      = 3'd6;

   localparam logic [DIM_W-1:0]   RST_SOURCE_WIDTH  = DIM_W'(512);
   localparam logic [DIM_W-1:0]   RST_SOURCE_HEIGHT = DIM_W'(424);
   localparam logic [DIM_W-1:0]   RST_OUT_WIDTH     = DIM_W'(512);
   localparam logic [DIM_W-1:0]   RST_OUT_HEIGHT    = DIM_W'(424);

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;
   localparam int Q_CW    = 3;
   localparam logic [Q_CW-1:0] Q_FULL_COUNT = Q_CW'(Q_DEPTH);

   typedef struct packed {
      logic [DIM_W-1:0]   source_width;
      logic [DIM_W-1:0]   source_height;
      logic [DIM_W-1:0]   out_width;
      logic [DIM_W-1:0]   out_height;
      logic [SCALE_W-1:0] scale_q16;
      logic [CNT_W-1:0]   crop_col;
      logic [CNT_W-1:0]   crop_row;
   } cfg_type;

   typedef struct packed {
      logic [MM_W-1:0]  depth_mm;
      logic [CNT_W-1:0] out_x;
      logic [CNT_W-1:0] out_y;
      logic             line_end;
      logic             frame_end;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== src/dcd_front.sv =====
`timescale 1ns / 1ps
module dcd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  dcd_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [dcd_pkg::MM_W-1:0]  req_depth_mm,
   input  logic                      req_frame_start,
   input  dcd_pkg::qstat_type        qstat,
   output dcd_pkg::push_type         push
);

   logic [dcd_pkg::CNT_W-1:0]  icc_ff, icc_in, irc_ff, irc_in;
   logic [dcd_pkg::CNT_W-1:0]  occ_ff, occ_in, orc_ff, orc_in;
   logic [dcd_pkg::ACC_W-1:0]  cacc_ff, cacc_in, racc_ff, racc_in;

   logic [dcd_pkg::CNT_W-1:0]   icc, irc, occ, orc;
   logic [dcd_pkg::ACC_W-1:0]   cacc, racc;
   logic [dcd_pkg::DIM_W-1:0]   sw, sh, ow, oh;
   logic [dcd_pkg::SCALE_W-1:0] step;
   logic [dcd_pkg::PICK_W-1:0]  tgt_row, tgt_col;
   logic [dcd_pkg::ACC_W:0]     csum, rsum;
   logic [dcd_pkg::ACC_W-1:0]   cacc_add, racc_add;
   logic                        accept, enabled, row_hit, col_hit, src_line_end;
   logic                        le, fe;

   always_comb begin
      sw = (cfg.source_width == '0) ? dcd_pkg::DIM_W'(1) :
           (cfg.source_width > dcd_pkg::MAX_DIM_V) ? dcd_pkg::MAX_DIM_V : cfg.source_width;
      sh = (cfg.source_height == '0) ? dcd_pkg::DIM_W'(1) :
           (cfg.source_height > dcd_pkg::MAX_DIM_V) ? dcd_pkg::MAX_DIM_V : cfg.source_height;
      ow = (cfg.out_width > dcd_pkg::MAX_DIM_V) ? dcd_pkg::MAX_DIM_V : cfg.out_width;
      oh = (cfg.out_height > dcd_pkg::MAX_DIM_V) ? dcd_pkg::MAX_DIM_V : cfg.out_height;
      step = (cfg.scale_q16 < dcd_pkg::SCALE_ONE) ? dcd_pkg::SCALE_ONE : cfg.scale_q16;
   end

   // frame start clears position before the word is judged
   always_comb begin
      icc  = req_frame_start ? '0 : icc_ff;
      irc  = req_frame_start ? '0 : irc_ff;
      occ  = req_frame_start ? '0 : occ_ff;
      orc  = req_frame_start ? '0 : orc_ff;
      cacc = req_frame_start ? '0 : cacc_ff;
      racc = req_frame_start ? '0 : racc_ff;
   end

   always_comb begin
      enabled = (ow <= sw) && (oh <= sh) && (ow != '0) && (oh != '0);
      tgt_row = dcd_pkg::PICK_W'(racc[dcd_pkg::ACC_W-1:dcd_pkg::FRAC_BITS])
              + dcd_pkg::PICK_W'(cfg.crop_row);
      tgt_col = dcd_pkg::PICK_W'(cacc[dcd_pkg::ACC_W-1:dcd_pkg::FRAC_BITS])
              + dcd_pkg::PICK_W'(cfg.crop_col);
      row_hit = enabled && (dcd_pkg::DIM_W'(orc) < oh)
              && (dcd_pkg::PICK_W'(irc) == tgt_row);
      col_hit = row_hit && (dcd_pkg::DIM_W'(occ) < ow)
              && (dcd_pkg::PICK_W'(icc) == tgt_col);
      le = (dcd_pkg::DIM_W'(occ) + dcd_pkg::DIM_W'(1)) == ow;
      fe = le && ((dcd_pkg::DIM_W'(orc) + dcd_pkg::DIM_W'(1)) == oh);
      src_line_end = (dcd_pkg::DIM_W'(icc) + dcd_pkg::DIM_W'(1)) >= sw;

      // saturating accumulators
      csum = (dcd_pkg::ACC_W+1)'(cacc) + (dcd_pkg::ACC_W+1)'(step);
      rsum = (dcd_pkg::ACC_W+1)'(racc) + (dcd_pkg::ACC_W+1)'(step);
      cacc_add = csum[dcd_pkg::ACC_W] ? '1 : csum[dcd_pkg::ACC_W-1:0];
      racc_add = rsum[dcd_pkg::ACC_W] ? '1 : rsum[dcd_pkg::ACC_W-1:0];
   end

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   always_comb begin
      icc_in  = icc_ff;
      irc_in  = irc_ff;
      occ_in  = occ_ff;
      orc_in  = orc_ff;
      cacc_in = cacc_ff;
      racc_in = racc_ff;
      if (accept) begin
         irc_in  = irc;
         orc_in  = orc;
         racc_in = racc;
         if (src_line_end) begin
            icc_in  = '0;
            irc_in  = irc + dcd_pkg::CNT_W'(1);
            occ_in  = '0;
            cacc_in = '0;
            if (row_hit) begin
               orc_in  = orc + dcd_pkg::CNT_W'(1);
               racc_in = racc_add;
            end
         end else begin
            icc_in  = icc + dcd_pkg::CNT_W'(1);
            occ_in  = col_hit ? occ + dcd_pkg::CNT_W'(1) : occ;
            cacc_in = col_hit ? cacc_add : cacc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icc_ff  <= '0;
         irc_ff  <= '0;
         occ_ff  <= '0;
         orc_ff  <= '0;
         cacc_ff <= '0;
         racc_ff <= '0;
      end else begin
         icc_ff  <= icc_in;
         irc_ff  <= irc_in;
         occ_ff  <= occ_in;
         orc_ff  <= orc_in;
         cacc_ff <= cacc_in;
         racc_ff <= racc_in;
      end
   end

   always_comb begin
      push.valid           = accept && col_hit;
      push.entry.depth_mm  = req_depth_mm;
      push.entry.out_x     = occ;
      push.entry.out_y     = orc;
      push.entry.line_end  = le;
      push.entry.frame_end = fe;
   end

endmodule

// ===== src/dcd_queue.sv =====
`timescale 1ns / 1ps
module dcd_queue (
   input  logic                clock,
   input  logic                reset,
   input  dcd_pkg::push_type   push,
   input  logic                pop,
   output dcd_pkg::qstat_type  qstat,
   output dcd_pkg::entry_type  head
);

   dcd_pkg::entry_type        mem_ff [dcd_pkg::Q_DEPTH];
   logic [dcd_pkg::Q_AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [dcd_pkg::Q_CW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + dcd_pkg::Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + dcd_pkg::Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + dcd_pkg::Q_CW'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - dcd_pkg::Q_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign qstat.full  = (count_ff == dcd_pkg::Q_FULL_COUNT);
   assign qstat.empty = (count_ff == '0);
   assign head        = mem_ff[rd_ptr_ff];

endmodule

// ===== src/dcd_back.sv =====
`timescale 1ns / 1ps
module dcd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  dcd_pkg::qstat_type           qstat,
   input  dcd_pkg::entry_type           head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dcd_pkg::DEPTH_W-1:0]  rsp_depth_m_q16,
   output logic [dcd_pkg::CNT_W-1:0]    rsp_out_x,
   output logic [dcd_pkg::CNT_W-1:0]    rsp_out_y,
   output logic                         rsp_line_end,
   output logic                         rsp_frame_end
);

   // stage 1: reciprocal multiply
   logic                          v1_ff, v1_in;
   logic [dcd_pkg::PROD_W-1:0]    prod_ff, prod_in;
   dcd_pkg::entry_type            meta_ff;
   // stage 2: output word
   logic                          ov_ff, ov_in;
   logic [dcd_pkg::DEPTH_W-1:0]   depth_ff;
   logic [dcd_pkg::CNT_W-1:0]     x_ff, y_ff;
   logic                          le_ff, fe_ff;

   logic [dcd_pkg::NUM_W-1:0]     numer;
   logic                          adv1, adv2;

   assign adv2 = !ov_ff || !rsp_stall;
   assign adv1 = !v1_ff || adv2;
   assign pop  = !qstat.empty && adv1;

   // mm*8192 + 62: the bias fits below the shifted sample
   assign numer   = {head.depth_mm, dcd_pkg::NUM_BIAS};
   assign prod_in = dcd_pkg::PROD_W'(numer) * dcd_pkg::PROD_W'(dcd_pkg::RECIP);

   assign v1_in = adv1 ? !qstat.empty : v1_ff;
   assign ov_in = adv2 ? v1_ff : ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         prod_ff <= prod_in;
         meta_ff <= head;
      end
      if (adv2) begin
         depth_ff <= prod_ff[dcd_pkg::DIV_SHIFT +: dcd_pkg::DEPTH_W];
         x_ff     <= meta_ff.out_x;
         y_ff     <= meta_ff.out_y;
         le_ff    <= meta_ff.line_end;
         fe_ff    <= meta_ff.frame_end;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_depth_m_q16 = depth_ff;
   assign rsp_out_x       = x_ff;
   assign rsp_out_y       = y_ff;
   assign rsp_line_end    = le_ff;
   assign rsp_frame_end   = fe_ff;

endmodule

// ===== src/depth_crop_downscale.sv =====
`timescale 1ns / 1ps
// channel | ports                                  | moves
// --------+----------------------------------------+--------------------------------
// req     | req_valid, req_stall, req_*            | one source depth word
// rsp     | rsp_valid, rsp_stall, rsp_*            | one kept pixel, metres Q7.16
// csr     | csr_we, csr_index, csr_wdata           | register write, no read-back
//
// One source word accepted per clock while req_stall is low; a kept word reaches rsp
// through the queue, the multiply register and the output register.
// req_stall rises only when the 4-word queue is full, i.e. after rsp_stall backs it up.
// Synchronous reset clears counters, queue and pipeline and loads register defaults.
`include "depth_crop_downscale_macros.svh"
module depth_crop_downscale (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [dcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dcd_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dcd_pkg::MM_W-1:0]       req_depth_mm,
   input  logic                           req_frame_start,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dcd_pkg::DEPTH_W-1:0]    rsp_depth_m_q16,
   output logic [dcd_pkg::CNT_W-1:0]      rsp_out_x,
   output logic [dcd_pkg::CNT_W-1:0]      rsp_out_y,
   output logic                           rsp_line_end,
   output logic                           rsp_frame_end
);

   dcd_pkg::cfg_type    cfg_ff, cfg_in;
   dcd_pkg::push_type   push;
   dcd_pkg::qstat_type  qstat;
   dcd_pkg::entry_type  head;
   logic                pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dcd_pkg::REG_SOURCE_WIDTH:  cfg_in.source_width  = csr_wdata[dcd_pkg::DIM_W-1:0];
            dcd_pkg::REG_SOURCE_HEIGHT: cfg_in.source_height = csr_wdata[dcd_pkg::DIM_W-1:0];
            dcd_pkg::REG_OUT_WIDTH:     cfg_in.out_width     = csr_wdata[dcd_pkg::DIM_W-1:0];
            dcd_pkg::REG_OUT_HEIGHT:    cfg_in.out_height    = csr_wdata[dcd_pkg::DIM_W-1:0];
            dcd_pkg::REG_SCALE_Q16:     cfg_in.scale_q16     = csr_wdata[dcd_pkg::SCALE_W-1:0];
            dcd_pkg::REG_CROP_COL:      cfg_in.crop_col      = csr_wdata[dcd_pkg::CNT_W-1:0];
            dcd_pkg::REG_CROP_ROW:      cfg_in.crop_row      = csr_wdata[dcd_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= dcd_pkg::RST_SOURCE_WIDTH;
         cfg_ff.source_height <= dcd_pkg::RST_SOURCE_HEIGHT;
         cfg_ff.out_width     <= dcd_pkg::RST_OUT_WIDTH;
         cfg_ff.out_height    <= dcd_pkg::RST_OUT_HEIGHT;
         cfg_ff.scale_q16     <= dcd_pkg::SCALE_ONE;
         cfg_ff.crop_col      <= '0;
         cfg_ff.crop_row      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dcd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_depth_mm    (req_depth_mm),
      .req_frame_start (req_frame_start),
      .qstat           (qstat),
      .push            (push)
   );

   dcd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .qstat (qstat),
      .head  (head)
   );

   dcd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_depth_m_q16 (rsp_depth_m_q16),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_line_end    (rsp_line_end),
      .rsp_frame_end   (rsp_frame_end)
   );

   `DCD_ASSERT_IMP(a_no_push_when_full, push.valid, !qstat.full)
   `DCD_ASSERT_NEXT(a_push_fills_queue, push.valid, !qstat.empty)
   `DCD_ASSERT_IMP(a_depth_in_range, rsp_valid, rsp_depth_m_q16 <= dcd_pkg::DEPTH_W'(4294902))
   `DCD_ASSERT_IMP(a_frame_end_ends_line, rsp_valid && rsp_frame_end, rsp_line_end)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import dcd_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_WORDS  = 400;
   localparam int DIR_ROWS      = 25;
   localparam int SMALL_CFG_ROW = 6;
   localparam logic [31:0] MM_PER_M   = 32'd1000;
   localparam logic [31:0] ROUND_HALF = MM_PER_M / 2;
   localparam logic [CSR_IDX_W-1:0] REG_ORDER [7] = '{REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT,
      REG_OUT_WIDTH, REG_OUT_HEIGHT, REG_SCALE_Q16, REG_CROP_COL, REG_CROP_ROW};

   typedef enum int {
      CFG_PLAIN, CFG_UPSCALE, CFG_ZERO_OUT, CFG_TINY_SOURCE, CFG_EXTREME, CFG_TALL, CFG_WIDE
   } cfg_kind_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_m;
      logic [CNT_W-1:0]   x;
      logic [CNT_W-1:0]   y;
      logic               line_end;
      logic               frame_end;
   } kept_pixel_type;

   typedef struct {
      logic [MM_W-1:0] mm;
      logic            fs;
      bit              typed;
      kept_pixel_type  px;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [MM_W-1:0]      req_depth_mm = '0;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DEPTH_W-1:0]   rsp_depth_m_q16;
   logic [CNT_W-1:0]     rsp_out_x;
   logic [CNT_W-1:0]     rsp_out_y;
   logic                 rsp_line_end;
   logic                 rsp_frame_end;

   depth_crop_downscale u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_depth_mm(req_depth_mm), .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_depth_m_q16(rsp_depth_m_q16), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_line_end(rsp_line_end), .rsp_frame_end(rsp_frame_end)
   );

   // shadow registers and position state of the picker
   cfg_type          shadow_cfg = '{RST_SOURCE_WIDTH, RST_SOURCE_HEIGHT, RST_OUT_WIDTH,
                                    RST_OUT_HEIGHT, SCALE_ONE, '0, '0};
   logic [CNT_W-1:0] src_col = '0, src_row = '0, dst_col = '0, dst_row = '0;
   logic [ACC_W-1:0] col_pick = '0, row_pick = '0;

   kept_pixel_type   pending_pixels[$];
   directed_row_type directed_rows[DIR_ROWS];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int errors = 0;
   int cycle_count = 0;
   int words_in = 0;
   int pixels_checked = 0;
   int plain_words = 0;
   int phase_no = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lo);
      if (v < lo) return lo;
      if (v > MAX_DIM_V) return MAX_DIM_V;
      return v;
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a, b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? '1 : s[ACC_W-1:0];
   endfunction

   // advances the source position by one word; returns 1 when the word is kept
   function automatic bit pick_pixel(input logic [MM_W-1:0] mm, input logic fs,
                                     output kept_pixel_type px);
      logic [DIM_W-1:0] sw, sh, ow, oh;
      logic [ACC_W-1:0] step_q, num;
      logic [PICK_W:0]  row_goal, col_goal;
      bit               on, row_hit, kept;
      sw = clamp_dim(shadow_cfg.source_width, DIM_W'(1));
      sh = clamp_dim(shadow_cfg.source_height, DIM_W'(1));
      ow = clamp_dim(shadow_cfg.out_width, '0);
      oh = clamp_dim(shadow_cfg.out_height, '0);
      step_q = (shadow_cfg.scale_q16 < SCALE_ONE) ? ACC_W'(SCALE_ONE)
                                                  : ACC_W'(shadow_cfg.scale_q16);
      if (fs) begin
         src_col = '0; src_row = '0; dst_col = '0; dst_row = '0;
         col_pick = '0; row_pick = '0;
      end
      on = ow <= sw && oh <= sh && ow != 0 && oh != 0;
      row_goal = (PICK_W + 1)'(row_pick[ACC_W-1:FRAC_BITS]) + (PICK_W + 1)'(shadow_cfg.crop_row);
      col_goal = (PICK_W + 1)'(col_pick[ACC_W-1:FRAC_BITS]) + (PICK_W + 1)'(shadow_cfg.crop_col);
      row_hit = on && DIM_W'(dst_row) < oh && (PICK_W + 1)'(src_row) == row_goal;
      kept = row_hit && DIM_W'(dst_col) < ow && (PICK_W + 1)'(src_col) == col_goal;
      px = '0;
      if (kept) begin
         num = {mm, 16'd0} + ROUND_HALF;
         px.depth_m = DEPTH_W'(num / MM_PER_M);
         px.x = dst_col;
         px.y = dst_row;
         px.line_end = DIM_W'(dst_col) + DIM_W'(1) == ow;
         px.frame_end = px.line_end && DIM_W'(dst_row) + DIM_W'(1) == oh;
         dst_col = dst_col + 1'b1;
         col_pick = sat_add(col_pick, step_q);
      end
      if (DIM_W'(src_col) + DIM_W'(1) >= sw) begin
         src_col = '0;
         src_row = src_row + 1'b1;
         if (row_hit) begin
            dst_row = dst_row + 1'b1;
            row_pick = sat_add(row_pick, step_q);
         end
         dst_col = '0;
         col_pick = '0;
      end else begin
         src_col = src_col + 1'b1;
      end
      return kept;
   endfunction

   function automatic cfg_type make_config(input cfg_kind_type kind);
      cfg_type c;
      int sw, sh, ow, oh, span;
      sw = $urandom_range(1, 10);
      sh = $urandom_range(1, 6);
      ow = $urandom_range(1, sw);
      oh = $urandom_range(1, sh);
      c.crop_col = CNT_W'($urandom_range(0, sw - ow));
      c.crop_row = CNT_W'($urandom_range(0, sh - oh));
      span = (sw - int'(c.crop_col)) * 65536 / ow;
      c.scale_q16 = SCALE_W'($urandom_range(65536, span));
      case (kind)
         CFG_UPSCALE: begin
            if ($urandom_range(0, 1)) ow = $urandom_range(0, 1) ? sw + 1 : 8191;
            else oh = $urandom_range(0, 1) ? sh + 1 : 8191;
         end
         CFG_ZERO_OUT: begin
            if ($urandom_range(0, 1)) ow = 0;
            else oh = 0;
         end
         CFG_TINY_SOURCE: begin
            // zero sizes clamp to one; scale under one counts as one
            sw = 0;
            sh = $urandom_range(0, 4);
            ow = 1;
            oh = $urandom_range(1, sh > 1 ? sh : 1);
            c.scale_q16 = SCALE_W'($urandom_range(0, 65535));
            c.crop_col = '0;
            c.crop_row = '0;
         end
         CFG_EXTREME: begin
            sw = 8; sh = 4; ow = 8; oh = 4;
            c.scale_q16 = '1;
            c.crop_col = $urandom_range(0, 1) ? '1 : '0;
            c.crop_row = $urandom_range(0, 1) ? '1 : '0;
         end
         CFG_TALL: begin
            // one-word lines, picks lines 1 and 63
            sw = 1; sh = 64; ow = 1; oh = 2;
            c.scale_q16 = SCALE_W'(62 * 65536);
            c.crop_col = '0;
            c.crop_row = CNT_W'(1);
         end
         CFG_WIDE: begin
            // picks columns 31 and 63 of line 1
            sw = 64; sh = 2; ow = 2; oh = 1;
            c.scale_q16 = SCALE_W'(32 * 65536);
            c.crop_col = CNT_W'(31);
            c.crop_row = CNT_W'(1);
         end
         default: ;
      endcase
      c.source_width = DIM_W'(sw);
      c.source_height = DIM_W'(sh);
      c.out_width = DIM_W'(ow);
      c.out_height = DIM_W'(oh);
      return c;
   endfunction

   task automatic load_config(input cfg_type c);
      logic [CSR_W-1:0] data;
      foreach (REG_ORDER[i]) begin
         case (REG_ORDER[i])
            REG_SOURCE_WIDTH:  data = CSR_W'(c.source_width);
            REG_SOURCE_HEIGHT: data = CSR_W'(c.source_height);
            REG_OUT_WIDTH:     data = CSR_W'(c.out_width);
            REG_OUT_HEIGHT:    data = CSR_W'(c.out_height);
            REG_SCALE_Q16:     data = CSR_W'(c.scale_q16);
            REG_CROP_COL:      data = CSR_W'(c.crop_col);
            default:           data = CSR_W'(c.crop_row);
         endcase
         csr_we <= 1'b1;
         csr_index <= REG_ORDER[i];
         csr_wdata <= data;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      shadow_cfg = c;
   endtask

   task automatic send_word(input logic [MM_W-1:0] mm, input logic fs,
                            input bit typed, input kept_pixel_type typed_px);
      kept_pixel_type px;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_depth_mm <= mm;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      words_in++;
      if (pick_pixel(mm, fs, px) || typed)
         pending_pixels.push_back(typed ? typed_px : px);
   endtask

   // hold off the sender until every kept pixel is out and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase();
      cfg_kind_type kind;
      cfg_type      c;
      int frame_words, target, pause_at, sent, span;
      if (phase_no <= CFG_WIDE) kind = cfg_kind_type'(phase_no);
      else if ($urandom_range(0, 9) < 7) kind = CFG_PLAIN;
      else kind = cfg_kind_type'($urandom_range(CFG_UPSCALE, CFG_EXTREME));
      c = make_config(kind);
      settle();
      load_config(c);
      case (phase_no % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
         default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
      endcase
      frame_words = int'(clamp_dim(c.source_width, DIM_W'(1)))
                  * int'(clamp_dim(c.source_height, DIM_W'(1)));
      if (kind == CFG_TALL || kind == CFG_WIDE) target = frame_words + 5;
      else target = $urandom_range(40, 90);
      pause_at = (phase_no == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, target - 1) : -1;
      sent = 0;
      while (sent < target) begin
         span = frame_words;
         if (frame_words <= 64) begin
            case ($urandom_range(0, 9))
               0: span = $urandom_range(1, frame_words);
               1: span = frame_words + $urandom_range(1, 8);
               default: ;
            endcase
         end
         for (int i = 0; i < span && sent < target; i++) begin
            if (sent == pause_at) settle();
            send_word(MM_W'($urandom), i == 0 || $urandom_range(0, 59) == 0, 1'b0, '0);
            sent++;
         end
      end
      if (kind != CFG_TALL && kind != CFG_WIDE) plain_words += sent;
      phase_no++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= $urandom_range(0, 99) < receiver_stall_pct;
   end

   function automatic void check_field(input string what, input logic [31:0] want, got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      kept_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, got depth %0d at (%0d,%0d)",
                     $time, rsp_depth_m_q16, rsp_out_x, rsp_out_y);
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            check_field("depth_m_q16", 32'(want.depth_m), 32'(rsp_depth_m_q16));
            check_field("out_x", 32'(want.x), 32'(rsp_out_x));
            check_field("out_y", 32'(want.y), 32'(rsp_out_y));
            check_field("line_end", 32'(want.line_end), 32'(rsp_line_end));
            check_field("frame_end", 32'(want.frame_end), 32'(rsp_frame_end));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      // after reset: 512-wide line at scale one, so each word maps to the next column
      directed_rows[0]  = '{16'd0,     1'b1, 1'b1, '{23'd0,       12'd0, 12'd0, 1'b0, 1'b0}};
      directed_rows[1]  = '{16'd65535, 1'b0, 1'b1, '{23'd4294902, 12'd1, 12'd0, 1'b0, 1'b0}};
      directed_rows[2]  = '{16'd1,     1'b0, 1'b1, '{23'd66,      12'd2, 12'd0, 1'b0, 1'b0}};
      directed_rows[3]  = '{16'd500,   1'b0, 1'b1, '{23'd32768,   12'd3, 12'd0, 1'b0, 1'b0}};
      directed_rows[4]  = '{16'd1000,  1'b0, 1'b1, '{23'd65536,   12'd4, 12'd0, 1'b0, 1'b0}};
      directed_rows[5]  = '{16'd3,     1'b0, 1'b1, '{23'd197,     12'd5, 12'd0, 1'b0, 1'b0}};
      // 4x3 source to 2x2 at scale 1.5, crop column 1: one full frame, overrun,
      // new frame, then a restart in the middle of a frame
      directed_rows[6]  = '{16'd65535, 1'b1, 1'b0, '0};
      directed_rows[7]  = '{16'd65535, 1'b0, 1'b0, '0};
      directed_rows[8]  = '{16'd0,     1'b0, 1'b0, '0};
      directed_rows[9]  = '{16'd1234,  1'b0, 1'b0, '0};
      directed_rows[10] = '{16'd4321,  1'b0, 1'b0, '0};
      directed_rows[11] = '{16'd32768, 1'b0, 1'b0, '0};
      directed_rows[12] = '{16'd32767, 1'b0, 1'b0, '0};
      directed_rows[13] = '{16'd999,   1'b0, 1'b0, '0};
      directed_rows[14] = '{16'd7,     1'b0, 1'b0, '0};
      directed_rows[15] = '{16'd65534, 1'b0, 1'b0, '0};
      directed_rows[16] = '{16'd8000,  1'b0, 1'b0, '0};
      directed_rows[17] = '{16'd1,     1'b0, 1'b0, '0};
      directed_rows[18] = '{16'd2500,  1'b0, 1'b0, '0};
      directed_rows[19] = '{16'd2501,  1'b0, 1'b0, '0};
      directed_rows[20] = '{16'd100,   1'b1, 1'b0, '0};
      directed_rows[21] = '{16'd200,   1'b0, 1'b0, '0};
      directed_rows[22] = '{16'd300,   1'b0, 1'b0, '0};
      directed_rows[23] = '{16'd400,   1'b1, 1'b0, '0};
      directed_rows[24] = '{16'd500,   1'b0, 1'b0, '0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (i == SMALL_CFG_ROW) begin
            settle();
            load_config('{DIM_W'(4), DIM_W'(3), DIM_W'(2), DIM_W'(2),
                          SCALE_W'(98304), CNT_W'(1), CNT_W'(0)});
         end
         send_word(directed_rows[i].mm, directed_rows[i].fs,
                   directed_rows[i].typed, directed_rows[i].px);
      end

      while (phase_no <= CFG_WIDE || plain_words < RANDOM_WORDS) run_phase();
      settle();

      $display("Ran %0d source words through %0d register settings,", words_in, phase_no + 2);
      $display("checked %0d kept pixels, %0d errors", pixels_checked, errors);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/dcd_pkg.sv
src/dcd_front.sv
src/dcd_queue.sv
src/dcd_back.sv
src/depth_crop_downscale.sv
tb/testbench.sv
